/* design/tpd_pkg.sv */
// Package for the TFTP-style packet deframer: opcodes, event kinds,
// decoder state and result types. Used by tpd_decoder and the core top level.
package tpd_pkg;

  localparam int unsigned PosW = 17;

  localparam logic [PosW-1:0] POS_MAX = {PosW{1'b1}};

  // Packet opcodes.
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [15:0] OP_BCAST = 16'd9;

  // Event kinds on the result channel.
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_PAYLOAD   = 3'd1;
  localparam logic [2:0] EV_EMPTY     = 3'd2;
  localparam logic [2:0] EV_ACK       = 3'd3;
  localparam logic [2:0] EV_ERROR     = 3'd4;
  localparam logic [2:0] EV_NAME      = 3'd5;
  localparam logic [2:0] EV_BCAST_END = 3'd6;
  localparam logic [2:0] EV_BAD_OP    = 3'd7;

  // Configuration register map and reset value.
  localparam logic REG_FULL_BLOCK_SIZE = 1'b0;
  localparam logic [15:0] FULL_BLOCK_SIZE_RST = 16'd512;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [15:0]     opcode;
    logic [15:0]     size;
    logic [15:0]     block;
    logic [15:0]     code;
    logic            added;
  } tpd_state_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  data_byte;
    logic        end_of_packet;
    logic [15:0] block_number;
    logic [15:0] err_code;
    logic        full_block;
    logic        file_added;
    logic [15:0] packet_opcode;
  } tpd_result_t;

endpackage

/* design/tpd_decoder.sv */
// Per-byte decode step of the packet deframer: from the framing state and one
// received byte it forms the next state and the result. Depends on tpd_pkg.
module tpd_decoder (
  input  tpd_pkg::tpd_state_t  cur_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [15:0]          full_block_size_i,
  output tpd_pkg::tpd_state_t  nxt_o,
  output tpd_pkg::tpd_result_t res_o
);
  import tpd_pkg::*;

  logic            eop;
  logic [PosW-1:0] data_last;
  logic [15:0]     op_full;

  assign data_last = {1'b0, cur_i.size} + PosW'(5);
  assign op_full   = {cur_i.opcode[15:8], rx_byte_i};

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    eop   = 1'b0;

    if (cur_i.pos == '0) begin
      nxt_o.opcode = {rx_byte_i, 8'h00};
    end else if (cur_i.pos == PosW'(1)) begin
      nxt_o.opcode        = op_full;
      res_o.packet_opcode = op_full;
      if (op_full != OP_DATA && op_full != OP_ACK && op_full != OP_ERROR &&
          op_full != OP_BCAST) begin
        res_o.event_kind = EV_BAD_OP;
        eop              = 1'b1;
      end
    end else begin
      res_o.packet_opcode = cur_i.opcode;
      unique case (cur_i.opcode)
        OP_DATA: begin
          if (cur_i.pos == PosW'(2)) begin
            nxt_o.size = {rx_byte_i, 8'h00};
          end else if (cur_i.pos == PosW'(3)) begin
            nxt_o.size = {cur_i.size[15:8], rx_byte_i};
          end else if (cur_i.pos == PosW'(4)) begin
            nxt_o.block = {rx_byte_i, 8'h00};
          end else if (cur_i.pos == PosW'(5)) begin
            nxt_o.block = {cur_i.block[15:8], rx_byte_i};
            if (cur_i.size == '0) begin
              res_o.event_kind = EV_EMPTY;
              eop              = 1'b1;
            end
          end else begin
            res_o.event_kind = EV_PAYLOAD;
            res_o.data_byte  = rx_byte_i;
            eop              = (cur_i.pos >= data_last);
          end
          if (eop) begin
            res_o.block_number = nxt_o.block;
            res_o.full_block   = (cur_i.size >= full_block_size_i);
          end
        end
        OP_ACK: begin
          if (cur_i.pos == PosW'(2)) begin
            nxt_o.block = {rx_byte_i, 8'h00};
          end else begin
            nxt_o.block        = {cur_i.block[15:8], rx_byte_i};
            res_o.event_kind   = EV_ACK;
            res_o.block_number = {cur_i.block[15:8], rx_byte_i};
            eop                = 1'b1;
          end
        end
        OP_ERROR: begin
          if (cur_i.pos == PosW'(2)) begin
            nxt_o.code = {rx_byte_i, 8'h00};
          end else if (cur_i.pos == PosW'(3)) begin
            nxt_o.code = {cur_i.code[15:8], rx_byte_i};
          end else if (rx_byte_i == 8'h00) begin
            res_o.event_kind = EV_ERROR;
            res_o.err_code   = cur_i.code;
            eop              = 1'b1;
          end
        end
        OP_BCAST: begin
          if (cur_i.pos == PosW'(2)) begin
            nxt_o.added = (rx_byte_i != 8'h00);
          end else if (rx_byte_i == 8'h00) begin
            res_o.event_kind = EV_BCAST_END;
            res_o.file_added = cur_i.added;
            eop              = 1'b1;
          end else begin
            res_o.event_kind = EV_NAME;
            res_o.data_byte  = rx_byte_i;
            res_o.file_added = cur_i.added;
          end
        end
        default: begin
          res_o.event_kind = EV_BAD_OP;
          eop              = 1'b1;
        end
      endcase
    end

    res_o.end_of_packet = eop;
    if (eop) begin
      nxt_o.pos = '0;
    end else if (cur_i.pos != POS_MAX) begin
      nxt_o.pos = cur_i.pos + PosW'(1);
    end
  end

endmodule

/* design/tftp_style_packet_deframer_core.sv */
// Top level of the TFTP-style packet deframer: input register, framing state,
// result register and the APB register port. Depends on tpd_pkg, tpd_decoder.
//
//   Channel  | Direction | Handshake          | Payload
//   ---------+-----------+--------------------+----------------------------------
//   rx       | in        | rx_valid_i/ready_o | rx_byte_i
//   ev       | out       | ev_valid_o/ready_i | event_kind_o .. packet_opcode_o
//   apb      | in        | psel/penable/pready| paddr, pwdata, prdata
//
// Every received byte yields exactly one result: it passes through the input
// register and then the result register. The sustained rate is one byte per
// clock while the result stream is not stalled, set by the single decode step
// between the two registers, which also updates the framing state. Reset
// clears the framing state and loads full_block_size with 512. A stalled result
// holds the result register; the input register still accepts one byte
// meanwhile and then holds it until the result register frees.
module tftp_style_packet_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Received byte stream.
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result stream.
  output logic        ev_valid_o,
  input  logic        ev_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  data_byte_o,
  output logic        end_of_packet_o,
  output logic [15:0] block_number_o,
  output logic [15:0] err_code_o,
  output logic        full_block_o,
  output logic        file_added_o,
  output logic [15:0] packet_opcode_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tpd_pkg::*;

  // Configuration register. The register index is paddr[2]; the lower two
  // address bits select a byte within the word and are ignored.
  logic [15:0] full_block_size_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FULL_BLOCK_SIZE);
  assign prdata = (paddr[2] == REG_FULL_BLOCK_SIZE) ? {16'h0000, full_block_size_q}
                                                    : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_block_size_q <= FULL_BLOCK_SIZE_RST;
    end else if (cfg_wr) begin
      full_block_size_q <= pwdata[15:0];
    end
  end

  // Two-stage pipeline. Stage one holds the received byte; stage two holds
  // the finished result. The framing state advances when a byte moves from
  // stage one into stage two, so the decode sees the state left by the
  // previous byte in every cycle.
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s2_valid_q;
  tpd_result_t s2_res_q;
  logic        s2_ready;
  logic        s2_load;
  logic        rx_take;

  tpd_state_t  state_q;
  tpd_state_t  state_d;
  tpd_result_t res_d;

  assign s2_ready   = !s2_valid_q || ev_ready_i;
  assign s2_load    = s1_valid_q && s2_ready;
  assign rx_ready_o = !s1_valid_q || s2_ready;
  assign rx_take    = rx_valid_i && rx_ready_o;

  tpd_decoder u_decoder (
    .cur_i             (state_q),
    .rx_byte_i         (s1_byte_q),
    .full_block_size_i (full_block_size_q),
    .nxt_o             (state_d),
    .res_o             (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (rx_ready_o) begin
        s1_valid_q <= rx_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s2_load) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      s1_byte_q <= rx_byte_i;
    end
    if (s2_load) begin
      s2_res_q <= res_d;
    end
  end

  assign ev_valid_o      = s2_valid_q;
  assign event_kind_o    = s2_res_q.event_kind;
  assign data_byte_o     = s2_res_q.data_byte;
  assign end_of_packet_o = s2_res_q.end_of_packet;
  assign block_number_o  = s2_res_q.block_number;
  assign err_code_o      = s2_res_q.err_code;
  assign full_block_o    = s2_res_q.full_block;
  assign file_added_o    = s2_res_q.file_added;
  assign packet_opcode_o = s2_res_q.packet_opcode;

  // A packet end always restarts framing at the first opcode byte.
  a_eop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load && res_d.end_of_packet |=> state_q.pos == '0)
    else $error("framing did not restart after a packet end");

  // A bad opcode always closes its packet.
  a_bad_op_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o && (event_kind_o == EV_BAD_OP) |-> end_of_packet_o)
    else $error("bad opcode result without packet end");

  // Every packet end carries an event; a quiet byte never ends a packet.
  a_none_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o && (event_kind_o == EV_NONE) |-> !end_of_packet_o)
    else $error("packet end reported with no event");

  // The zero byte terminates a name, so a name byte is never zero.
  a_name_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o && (event_kind_o == EV_NAME) |-> data_byte_o != 8'h00)
    else $error("zero byte streamed as a name byte");

  // The input side only stalls while a byte waits in the input register.
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> s1_valid_q && s2_valid_q)
    else $error("input stalled with room in the pipeline");

endmodule
